/* sv/sitda_pkg.sv */
// Shared types and constants for the signed integer to decimal text converter.
package sitda_pkg;

    localparam int ValueWidth    = 64;
    localparam int DigitCount    = 20;
    localparam int BcdWidth      = DigitCount * 4;
    localparam int BitCountWidth = $clog2(ValueWidth);
    localparam int CountWidth    = 5;

    localparam logic [7:0] CharZero  = 8'd48;
    localparam logic [7:0] CharMinus = 8'd45;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic start;
        logic digit_shift;
    } dab_ctrl_t;

    typedef struct packed {
        logic       done;
        logic       busy;
        logic [3:0] top_digit;
    } dab_stat_t;

endpackage

/* sv/sitda_dabble.sv */
// Bit-serial binary to BCD converter (shift and add three) with a digit shift out.
module sitda_dabble
    import sitda_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dab_ctrl_t             ctrl,
    input  logic [ValueWidth-1:0] magnitude,
    output dab_stat_t             stat
);

    logic [BcdWidth-1:0]      bcd_reg, bcd_next, bcd_adj;
    logic [ValueWidth-1:0]    mag_reg, mag_next;
    logic [BitCountWidth-1:0] bit_cnt_reg, bit_cnt_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;

    // Every digit of five or more gets three added before the next doubling.
    always_comb begin
        logic [3:0] d;
        for (int i = 0; i < DigitCount; i++) begin
            d = bcd_reg[i*4 +: 4];
            bcd_adj[i*4 +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
        end
    end

    always_comb begin
        bcd_next     = bcd_reg;
        mag_next     = mag_reg;
        bit_cnt_next = bit_cnt_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        if (ctrl.start) begin
            mag_next     = magnitude;
            bcd_next     = '0;
            bit_cnt_next = '0;
            busy_next    = 1'b1;
        end else if (busy_reg) begin
            bcd_next     = {bcd_adj[BcdWidth-2:0], mag_reg[ValueWidth-1]};
            mag_next     = {mag_reg[ValueWidth-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg + 1'b1;
            if (bit_cnt_reg == BitCountWidth'(ValueWidth - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (ctrl.digit_shift) begin
            bcd_next = {bcd_reg[BcdWidth-5:0], 4'b0000};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        bcd_reg     <= bcd_next;
        mag_reg     <= mag_next;
        bit_cnt_reg <= bit_cnt_next;
    end

    assign stat.done      = done_reg;
    assign stat.busy      = busy_reg;
    assign stat.top_digit = bcd_reg[BcdWidth-1 -: 4];

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.start |-> !busy_reg)
        else $error("conversion started while one is running");

    a_shift_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.digit_shift |-> !busy_reg)
        else $error("digit shift requested during conversion");

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("done raised without a finished conversion");

endmodule

/* sv/signed_int_to_decimal_ascii.sv */
// Top level: signed 64-bit integer to decimal ASCII text, one character per transfer.
//
//   channel   direction   handshake            payload
//   s_        in          s_valid / s_ready    s_value (64, signed)
//   m_        out         m_valid / m_ready    m_character (8), m_last (1), m_length (5)
//
// An item is accepted, runs the bit-serial shift-and-add-three loop over all 64 bits,
// the finish of that loop is seen, each leading zero digit is stripped and the first
// digit found, and then each character is emitted as the output takes it.
// Reset is synchronous and active low; it clears the sequencer and the output valid.
// A stalled output holds its character; the next value may be accepted while the
// final character of the previous one still waits in the output register.
module signed_int_to_decimal_ascii
    import sitda_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [ValueWidth-1:0] s_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [7:0]                   m_character,
    output logic                         m_last,
    output logic [CountWidth-1:0]        m_length
);

    state_t                state_reg, state_next;
    logic                  neg_reg, neg_next;
    logic                  sign_pending_reg, sign_pending_next;
    logic [CountWidth-1:0] cnt_reg, cnt_next;
    logic [CountWidth-1:0] len_reg, len_next;
    logic                  m_valid_reg, m_valid_next;
    logic [7:0]            m_character_reg, m_character_next;
    logic                  m_last_reg, m_last_next;
    logic [CountWidth-1:0] m_length_reg, m_length_next;

    logic [ValueWidth-1:0] value_u;
    logic [ValueWidth-1:0] magnitude;
    dab_ctrl_t             dab_ctrl;
    dab_stat_t             dab_stat;
    logic                  load;

    // The magnitude of the most negative value still fits as an unsigned word.
    assign value_u   = $unsigned(s_value);
    assign magnitude = value_u[ValueWidth-1] ? (~value_u + 64'd1) : value_u;

    sitda_dabble u_dabble (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (dab_ctrl),
        .magnitude (magnitude),
        .stat      (dab_stat)
    );

    always_comb begin
        state_next        = state_reg;
        neg_next          = neg_reg;
        sign_pending_next = sign_pending_reg;
        cnt_next          = cnt_reg;
        len_next          = len_reg;
        m_valid_next      = m_valid_reg;
        m_character_next  = m_character_reg;
        m_last_next       = m_last_reg;
        m_length_next     = m_length_reg;
        dab_ctrl          = '0;
        s_ready           = 1'b0;
        load              = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    dab_ctrl.start = 1'b1;
                    neg_next       = value_u[ValueWidth-1];
                    state_next     = ST_CONVERT;
                end
            end
            ST_CONVERT: begin
                if (dab_stat.done) begin
                    cnt_next   = CountWidth'(DigitCount);
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Leading zeros are dropped, but a zero value keeps its one digit.
                if (dab_stat.top_digit == 4'd0 && cnt_reg > 5'd1) begin
                    dab_ctrl.digit_shift = 1'b1;
                    cnt_next             = cnt_reg - 5'd1;
                end else begin
                    len_next          = cnt_reg + {4'b0000, neg_reg};
                    sign_pending_next = neg_reg;
                    state_next        = ST_EMIT;
                end
            end
            ST_EMIT: begin
                load = !m_valid_reg || m_ready;
                if (load) begin
                    m_valid_next  = 1'b1;
                    m_length_next = len_reg;
                    if (sign_pending_reg) begin
                        m_character_next  = CharMinus;
                        m_last_next       = 1'b0;
                        sign_pending_next = 1'b0;
                    end else begin
                        m_character_next     = CharZero + {4'b0000, dab_stat.top_digit};
                        m_last_next          = (cnt_reg == 5'd1);
                        dab_ctrl.digit_shift = 1'b1;
                        cnt_next             = cnt_reg - 5'd1;
                        if (cnt_reg == 5'd1) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        neg_reg          <= neg_next;
        sign_pending_reg <= sign_pending_next;
        cnt_reg          <= cnt_next;
        len_reg          <= len_next;
        m_character_reg  <= m_character_next;
        m_last_reg       <= m_last_next;
        m_length_reg     <= m_length_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_character = m_character_reg;
    assign m_last      = m_last_reg;
    assign m_length    = m_length_reg;

    a_done_in_convert: assert property (@(posedge aclk) disable iff (!aresetn)
        dab_stat.done |-> state_reg == ST_CONVERT)
        else $error("conversion finished outside the convert state");

    a_emit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT |-> cnt_reg != 5'd0 && !dab_stat.busy)
        else $error("emitting with no digits left");

    a_char_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_character == CharMinus ||
                     (m_character >= CharZero && m_character <= CharZero + 8'd9)))
        else $error("output character is neither a digit nor a minus sign");

    a_minus_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_character == CharMinus |-> !m_last && m_length >= 5'd2)
        else $error("minus sign marked as final character");

endmodule
